// ===== hdl/tcn_pkg.sv =====
// Package for the tap coordinate normalizer: payload structs, register
// indexes, transform codes and the orientation-to-transform lookup.
// No dependencies.
`timescale 1ns / 1ps

package tcn_pkg;

   localparam int COORD_BITS = 16;
   localparam int DUR_BITS   = 32;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type           tap_x;
      coord_type           tap_y;
      coord_type           view_width;
      coord_type           view_height;
      logic [2:0]          user_orient;
      logic [1:0]          scale_ratio;
      logic [DUR_BITS-1:0] duration;
   } req_type;

   typedef struct packed {
      coord_type           out_x;
      coord_type           out_y;
      logic [DUR_BITS-1:0] out_duration;
      logic                status;
   } rsp_type;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_BITS-1:0] CSR_DISPLAY_ORIENT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SWAP_AXES      = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT_X        = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT_Y        = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_DURATION   = 3'd4;

   // User orientation codes
   localparam logic [2:0] UO_ROT0      = 3'd0;
   localparam logic [2:0] UO_ROT90     = 3'd1;
   localparam logic [2:0] UO_ROT180    = 3'd2;
   localparam logic [2:0] UO_ROT270    = 3'd3;
   localparam logic [2:0] UO_MIRROR    = 3'd4;
   localparam logic [2:0] UO_PORTRAIT  = 3'd5;
   localparam logic [2:0] UO_LANDSCAPE = 3'd6;
   localparam logic [2:0] UO_INVALID   = 3'd7;

   // Scale codes
   localparam logic [1:0] SCALE_X1 = 2'd0;
   localparam logic [1:0] SCALE_X2 = 2'd1;
   localparam logic [1:0] SCALE_X3 = 2'd2;

   typedef enum logic [2:0] {
      XF_ID,
      XF_SWAPY,
      XF_BOTH,
      XF_SWAPX,
      XF_MIRX
   } xform_type;

   // Pick the transform for a display rotation and a normalized user
   // orientation (rotations and mirror only).
   function automatic xform_type xform_select(input logic [1:0] disp, input logic [2:0] uo);
      xform_type xf;
      xf = XF_ID;
      if (uo == UO_MIRROR) begin
         xf = XF_MIRX;
      end else begin
         case ({disp, uo[1:0]})
            4'b00_00: xf = XF_ID;
            4'b00_01: xf = XF_SWAPY;
            4'b00_10: xf = XF_BOTH;
            4'b00_11: xf = XF_SWAPX;
            4'b01_00: xf = XF_SWAPX;
            4'b01_01: xf = XF_ID;
            4'b01_10: xf = XF_SWAPY;
            4'b01_11: xf = XF_BOTH;
            4'b10_00: xf = XF_BOTH;
            4'b10_01: xf = XF_SWAPX;
            4'b10_10: xf = XF_SWAPY;
            4'b10_11: xf = XF_ID;
            4'b11_00: xf = XF_SWAPY;
            4'b11_01: xf = XF_BOTH;
            4'b11_10: xf = XF_SWAPX;
            4'b11_11: xf = XF_ID;
            default:  xf = XF_ID;
         endcase
      end
      return xf;
   endfunction

endpackage

// ===== hdl/tap_coordinate_normalizer.sv =====
// Top level of the tap coordinate normalizer: configuration registers and a
// two-stage transform pipeline from viewer space to device space.
// Depends on tcn_pkg.
`timescale 1ns / 1ps
//
//  channel   direction  ports                          transfer when
//  --------  ---------  -----------------------------  ---------------------
//  request   in         start, busy, req_data          start && !busy
//  result    out        rsp_valid, rsp_data            rsp_valid (one cycle)
//  config    in         csr_we, csr_index, csr_wdata   csr_we
//
//  One tap enters every cycle; busy is never raised. Each result is registered
//  twice after its request transfer: stage one normalizes the orientation,
//  scales the coordinates and picks the transform; stage two mirrors or swaps,
//  clamps and registers the result. Synchronous reset clears the valid flags
//  and all configuration registers. The receiver cannot stall, so results are
//  never held: each strobe lasts exactly one cycle.

module tap_coordinate_normalizer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  tcn_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output tcn_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [tcn_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tcn_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import tcn_pkg::*;

   // Configuration registers
   logic [1:0]          display_orient_ff;
   logic                swap_axes_ff;
   coord_type           limit_x_ff;
   coord_type           limit_y_ff;
   logic [DUR_BITS-1:0] max_duration_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         display_orient_ff <= '0;
         swap_axes_ff      <= 1'b0;
         limit_x_ff        <= '0;
         limit_y_ff        <= '0;
         max_duration_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DISPLAY_ORIENT: display_orient_ff <= csr_wdata[1:0];
            CSR_SWAP_AXES:      swap_axes_ff      <= csr_wdata[0];
            CSR_LIMIT_X:        limit_x_ff        <= csr_wdata[COORD_BITS-1:0];
            CSR_LIMIT_Y:        limit_y_ff        <= csr_wdata[COORD_BITS-1:0];
            CSR_MAX_DURATION:   max_duration_ff   <= csr_wdata[DUR_BITS-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // Every cycle is open for a new tap
   assign busy = 1'b0;

   // ---------------- Stage one: normalize, scale, pick transform ------------
   logic                s1_valid_in;
   logic                s1_valid_ff;
   logic [2:0]          uo_norm;
   logic                invalid_in;
   coord_type           sx_in;
   coord_type           sy_in;
   xform_type           xform_in;

   coord_type           sx_ff;
   coord_type           sy_ff;
   coord_type           w_ff;
   coord_type           h_ff;
   xform_type           xform_ff;
   logic                invalid_ff;
   logic [DUR_BITS-1:0] dur_ff;

   assign s1_valid_in = start && !busy;

   always_comb begin
      // Portrait is 0 degrees, landscape is 270 degrees
      case (req_data.user_orient)
         UO_PORTRAIT:  uo_norm = UO_ROT0;
         UO_LANDSCAPE: uo_norm = UO_ROT270;
         default:      uo_norm = req_data.user_orient;
      endcase
      invalid_in = (uo_norm == UO_INVALID);

      // Scale wraps at the coordinate width; the unused code scales by one
      case (req_data.scale_ratio)
         SCALE_X2: begin
            sx_in = req_data.tap_x << 1;
            sy_in = req_data.tap_y << 1;
         end
         SCALE_X3: begin
            sx_in = req_data.tap_x + (req_data.tap_x << 1);
            sy_in = req_data.tap_y + (req_data.tap_y << 1);
         end
         default: begin
            sx_in = req_data.tap_x;
            sy_in = req_data.tap_y;
         end
      endcase

      xform_in = xform_select(display_orient_ff, uo_norm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Payload advances on every transfer; no reset needed
   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         sx_ff      <= sx_in;
         sy_ff      <= sy_in;
         w_ff       <= req_data.view_width;
         h_ff       <= req_data.view_height;
         xform_ff   <= xform_in;
         invalid_ff <= invalid_in;
         dur_ff     <= req_data.duration;
      end
   end

   // ---------------- Stage two: transform, clamp, register result -----------
   coord_type nx;
   coord_type ny;
   coord_type lim_for_x;
   coord_type lim_for_y;
   rsp_type   rsp_in;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;

   always_comb begin
      case (xform_ff)
         XF_SWAPY: begin
            nx = sy_ff;
            ny = h_ff - sx_ff;
         end
         XF_BOTH: begin
            nx = w_ff - sx_ff;
            ny = h_ff - sy_ff;
         end
         XF_SWAPX: begin
            nx = w_ff - sy_ff;
            ny = sx_ff;
         end
         XF_MIRX: begin
            nx = w_ff - sx_ff;
            ny = sy_ff;
         end
         default: begin
            nx = sx_ff;
            ny = sy_ff;
         end
      endcase

      // Exchange the axis limits when the device axes are swapped
      lim_for_x = swap_axes_ff ? limit_y_ff : limit_x_ff;
      lim_for_y = swap_axes_ff ? limit_x_ff : limit_y_ff;

      rsp_in = '0;
      if (invalid_ff) begin
         // Unsupported orientation: zero the fields and flag the error
         rsp_in.status = 1'b1;
      end else begin
         // A coordinate limit of zero means no clamp; a duration cap of zero clamps to zero
         rsp_in.out_x = (lim_for_x != '0 && lim_for_x < nx) ? lim_for_x : nx;
         rsp_in.out_y = (lim_for_y != '0 && lim_for_y < ny) ? lim_for_y : ny;
         rsp_in.out_duration = (max_duration_ff < dur_ff) ? max_duration_ff : dur_ff;
         rsp_in.status = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/tcn_checker.sv =====
// Port-level checker for the tap coordinate normalizer, bound to the top
// level. Depends on tcn_pkg and tap_coordinate_normalizer.
`timescale 1ns / 1ps

module tcn_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input tcn_pkg::req_type  req_data,
   input logic              rsp_valid,
   input tcn_pkg::rsp_type  rsp_data
);
   import tcn_pkg::*;

   // Every request transfer yields a result once it has passed both pipeline registers
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("result missing two cycles after transfer");

   // No result without a matching earlier request transfer
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a matching request");

   // Error status follows an invalid orientation code
   a_status_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == $past(req_data.user_orient == UO_INVALID, 2)))
      else $error("status does not match the request orientation");

   // An error result carries zero fields
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |->
         (rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_duration == '0))
      else $error("error result carries nonzero fields");

endmodule

bind tap_coordinate_normalizer tcn_checker u_tcn_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== tb/tap_scoreboard.sv =====
// Scoreboard for the tap coordinate normalizer: mirrors the register file,
// predicts each result from the request transfer and checks every strobe.
// Depends on tcn_pkg.
`timescale 1ns / 1ps

module tap_scoreboard (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  tcn_pkg::req_type                    req_data,
   input  logic                                rsp_valid,
   input  tcn_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [tcn_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tcn_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output int                                  fail_count,
   output int                                  pending
);

   import tcn_pkg::*;

   logic [1:0]          disp_orient;
   logic                swap_axes;
   coord_type           limit_x;
   coord_type           limit_y;
   logic [DUR_BITS-1:0] max_duration;

   rsp_type             expected_taps[$];

   // Transform for a display rotation and a rotation-only user orientation.
   function automatic xform_type rotation_xform(input logic [1:0] disp,
                                                input logic [1:0] rot);
      case ({disp, rot})
         4'b00_00: return XF_ID;
         4'b00_01: return XF_SWAPY;
         4'b00_10: return XF_BOTH;
         4'b00_11: return XF_SWAPX;
         4'b01_00: return XF_SWAPX;
         4'b01_01: return XF_ID;
         4'b01_10: return XF_SWAPY;
         4'b01_11: return XF_BOTH;
         4'b10_00: return XF_BOTH;
         4'b10_01: return XF_SWAPX;
         4'b10_10: return XF_SWAPY;
         4'b10_11: return XF_ID;
         4'b11_00: return XF_SWAPY;
         4'b11_01: return XF_BOTH;
         4'b11_10: return XF_SWAPX;
         default:  return XF_ID;
      endcase
   endfunction

   function automatic coord_type clamp_coord(input coord_type v, input coord_type lim);
      return (lim != '0 && lim < v) ? lim : v;
   endfunction

   function automatic rsp_type normalize_tap(input req_type r);
      rsp_type    o;
      coord_type  x, y, nx, ny;
      logic [2:0] uo;
      xform_type  xf;
      o  = '0;
      uo = r.user_orient;
      if (uo == UO_PORTRAIT) begin
         uo = UO_ROT0;
      end else if (uo == UO_LANDSCAPE) begin
         uo = UO_ROT270;
      end
      if (uo == UO_INVALID) begin
         o.status = 1'b1;
         return o;
      end
      // scaling wraps at the coordinate width; the spare code scales by one
      case (r.scale_ratio)
         SCALE_X2: begin
            x = r.tap_x << 1;
            y = r.tap_y << 1;
         end
         SCALE_X3: begin
            x = r.tap_x + (r.tap_x << 1);
            y = r.tap_y + (r.tap_y << 1);
         end
         default: begin
            x = r.tap_x;
            y = r.tap_y;
         end
      endcase
      xf = (uo == UO_MIRROR) ? XF_MIRX : rotation_xform(disp_orient, uo[1:0]);
      case (xf)
         XF_SWAPY: begin nx = y;                 ny = r.view_height - x; end
         XF_BOTH:  begin nx = r.view_width - x;  ny = r.view_height - y; end
         XF_SWAPX: begin nx = r.view_width - y;  ny = x;                 end
         XF_MIRX:  begin nx = r.view_width - x;  ny = y;                 end
         default:  begin nx = x;                 ny = y;                 end
      endcase
      o.out_x = clamp_coord(nx, swap_axes ? limit_y : limit_x);
      o.out_y = clamp_coord(ny, swap_axes ? limit_x : limit_y);
      o.out_duration = (max_duration < r.duration) ? max_duration : r.duration;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         disp_orient  = '0;
         swap_axes    = 1'b0;
         limit_x      = '0;
         limit_y      = '0;
         max_duration = '0;
         expected_taps.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DISPLAY_ORIENT: disp_orient  = csr_wdata[1:0];
               CSR_SWAP_AXES:      swap_axes    = csr_wdata[0];
               CSR_LIMIT_X:        limit_x      = csr_wdata[COORD_BITS-1:0];
               CSR_LIMIT_Y:        limit_y      = csr_wdata[COORD_BITS-1:0];
               CSR_MAX_DURATION:   max_duration = csr_wdata[DUR_BITS-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_taps.push_back(normalize_tap(req_data));
         end
         if (rsp_valid) begin
            if (expected_taps.size() == 0) begin
               $display("%0t: result with nothing expected, actual 0x%0h", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_taps.pop_front();
               check_field("out_x", want.out_x, rsp_data.out_x);
               check_field("out_y", want.out_y, rsp_data.out_y);
               check_field("out_duration", want.out_duration, rsp_data.out_duration);
               check_field("status", want.status, rsp_data.status);
            end
         end
      end
      pending = expected_taps.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the tap coordinate normalizer testbench: clock, reset, register
// programming and tap stimulus, plus the verdict. Depends on tcn_pkg,
// tap_coordinate_normalizer and tap_scoreboard.
`timescale 1ns / 1ps

module testbench;

   import tcn_pkg::*;

   localparam int         PHASES         = 7;
   localparam int         TAPS_PER_PHASE = 200;
   localparam int         STALL_LIMIT    = 1000;
   localparam logic [1:0] SCALE_SPARE    = 2'd3;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     start     = 1'b0;
   logic                     busy;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   rsp_type                  rsp_data;
   logic                     csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int                       fail_count;
   int                       pending;
   int                       stall_cycles = 0;
   logic [DUR_BITS-1:0]      cur_max_duration = '0;

   always #5 clock = ~clock;

   tap_coordinate_normalizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tap_scoreboard u_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Watchdog: any transfer, result or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic req_type tap_req(input coord_type x, input coord_type y,
                                       input coord_type w, input coord_type h,
                                       input logic [2:0] uo, input logic [1:0] sr,
                                       input logic [DUR_BITS-1:0] dur);
      req_type r;
      r.tap_x       = x;
      r.tap_y       = y;
      r.view_width  = w;
      r.view_height = h;
      r.user_orient = uo;
      r.scale_ratio = sr;
      r.duration    = dur;
      return r;
   endfunction

   // Lean toward the edges of the range so wrap and clamp corners show up.
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return coord_type'($urandom_range(0, 255));
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Durations cluster around the current cap to hit both sides of the clamp.
   function automatic logic [DUR_BITS-1:0] rand_duration(input logic [DUR_BITS-1:0] cap);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return cap;
         3:       return cap + 1;
         4:       return cap - 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic coord_type rand_limit();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         2:       return coord_type'($urandom_range(1, 1023));
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Drive one tap and hold it until the transfer; start stays high so the
   // next tap can follow back to back.
   task automatic send_tap(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and wait for every expected result; check on the falling
   // edge so the scoreboard has settled, return on a rising edge.
   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Reprogram every register, with junk in the unused upper bits of the narrow
   // ones, then poke an unmapped index that must change nothing.
   task automatic program_regs(input logic [1:0] disp, input logic swap,
                               input coord_type lim_x, input coord_type lim_y,
                               input logic [DUR_BITS-1:0] max_dur);
      wait_drained();
      write_reg(CSR_DISPLAY_ORIENT, {30'($urandom), disp});
      write_reg(CSR_SWAP_AXES, {31'($urandom), swap});
      write_reg(CSR_LIMIT_X, {16'($urandom), lim_x});
      write_reg(CSR_LIMIT_Y, {16'($urandom), lim_y});
      write_reg(CSR_MAX_DURATION, max_dur);
      write_reg(CSR_IDX_BITS'($urandom_range(CSR_MAX_DURATION + 1,
                                             (1 << CSR_IDX_BITS) - 1)), $urandom);
      csr_we <= 1'b0;
      cur_max_duration = max_dur;
   endtask

   initial begin
      int gap_odds;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed taps at reset values: no coordinate clamp, duration cap 0.
      send_tap(tap_req(16'h0000, 16'h0000, 16'h0000, 16'h0000, UO_ROT0, SCALE_X1, '0));
      send_tap(tap_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, UO_ROT0, SCALE_X1, '1));
      send_tap(tap_req(16'h1234, 16'h5678, 16'hFFFF, 16'hFFFF, UO_ROT90, SCALE_X2, 32'd100));
      send_tap(tap_req(16'h8000, 16'h7FFF, 16'h0100, 16'h0200, UO_ROT180, SCALE_X3, '1));
      send_tap(tap_req(16'hFFFF, 16'h0001, 16'h0000, 16'h0000, UO_ROT270, SCALE_X3, 32'd1));
      send_tap(tap_req(16'h0010, 16'h0020, 16'h0030, 16'h0040, UO_MIRROR, SCALE_X1, 32'd5));
      send_tap(tap_req(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, UO_PORTRAIT, SCALE_X2,
                       32'hAAAA_AAAA));
      send_tap(tap_req(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, UO_LANDSCAPE, SCALE_X1,
                       32'h5555_5555));
      send_tap(tap_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, UO_INVALID, SCALE_X3, '1));
      send_tap(tap_req(16'h4321, 16'h8765, 16'h1000, 16'h2000, UO_ROT0, SCALE_SPARE,
                       32'd7));
      send_tap(tap_req(16'h0001, 16'h0002, 16'h0003, 16'h0004, UO_INVALID, SCALE_SPARE,
                       32'd9));

      // Directed taps with swapped axes, 270 degree display and tight limits:
      // land exactly on the limits, then one above them.
      program_regs(2'd3, 1'b1, 16'h0100, 16'h0FFF, 32'd1000);
      send_tap(tap_req(16'h0010, 16'h0FFF, 16'h0000, 16'h0110, UO_ROT0, SCALE_X1, 32'd1000));
      send_tap(tap_req(16'h0010, 16'h1000, 16'h0000, 16'h0111, UO_ROT0, SCALE_X1, 32'd1001));
      send_tap(tap_req(16'h0123, 16'h0456, 16'h0FFF, 16'h00FF, UO_ROT90, SCALE_X2, 32'd999));
      send_tap(tap_req(16'h7FFF, 16'h0001, 16'hFFFF, 16'hFFFF, UO_ROT180, SCALE_X3, '0));
      send_tap(tap_req(16'h0050, 16'h0060, 16'h0200, 16'h0300, UO_ROT270, SCALE_X1, '1));
      send_tap(tap_req(16'h0050, 16'h0060, 16'h0200, 16'h0300, UO_MIRROR, SCALE_X2, 32'd3));
      send_tap(tap_req(16'h0050, 16'h0060, 16'h0200, 16'h0300, UO_LANDSCAPE, SCALE_X1,
                       32'd4));

      // Random phases: each display rotation, both swap settings, and limits
      // from none to the full range.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: program_regs(2'd0, 1'b0, 16'hFFFF, 16'hFFFF, '0);
            1: program_regs(2'd1, 1'b1, 16'h0000, 16'h0000, '1);
            2: program_regs(2'd2, 1'($urandom), rand_limit(), rand_limit(), $urandom);
            3: program_regs(2'd3, 1'b1, coord_type'($urandom_range(1, 4095)),
                            coord_type'($urandom_range(1, 4095)), $urandom_range(0, 1000));
            default: program_regs(2'($urandom), 1'($urandom), rand_limit(), rand_limit(),
                                  $urandom);
         endcase
         // alternate busy and sparse idling; the last phase runs flat out
         gap_odds = (p % 2 == 0) ? 2 : 9;
         for (int i = 0; i < TAPS_PER_PHASE; i++) begin
            send_tap(tap_req(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                             rand_duration(cur_max_duration)));
            if (i == TAPS_PER_PHASE / 2) begin
               // let the pipeline run dry once per phase
               wait_drained();
            end else if (p != PHASES - 1 && $urandom_range(0, gap_odds) == 0) begin
               hold_off($urandom_range(1, 7));
            end
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
